FILE: rtl/core/tlnef_pkg.sv
package tlnef_pkg;

  // line counter width in decimal digits
  localparam int NUMBER_DIGITS_DEF = 6;
  // entries between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_LINES     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd4;

  // numbering modes
  localparam logic [1:0] NUM_ALL      = 2'd1;
  localparam logic [1:0] NUM_NONBLANK = 2'd2;

  // character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [6:0] LOW_DEL   = 7'd127;
  localparam logic [6:0] LOW_CTRL_MAX = 7'd31;
  localparam logic [7:0] CARET_OFFSET = 8'd64;

  // classified request handed from front to back
  typedef struct packed {
    logic            num_en;     // line number precedes the characters
    logic [3:0][7:0] chars;      // character bytes, index 0 first
    logic [1:0]      chars_last; // index of the final character byte
  } tlnef_cmd_t;

endpackage

FILE: rtl/core/tlnef_if.sv
interface tlnef_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

interface tlnef_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

interface tlnef_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tlnef_pkg::CFG_IDX_W-1:0]  index;
  logic [tlnef_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/tlnef_front.sv
module tlnef_front #(
  parameter int NUMBER_DIGITS = tlnef_pkg::NUMBER_DIGITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_data_byte,
  input  logic                              in_file_start,
  input  logic                              cfg_valid,
  input  logic [tlnef_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tlnef_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                              push_valid,
  input  logic                              push_ready,
  output tlnef_pkg::tlnef_cmd_t             push_cmd,
  output logic [NUMBER_DIGITS-1:0][3:0]     push_digits
);
  import tlnef_pkg::*;

  logic [1:0] number_lines_r;
  logic       squeeze_blank_r;
  logic       show_ends_r;
  logic       show_tabs_r;
  logic       show_nonprinting_r;

  logic                          at_line_start_r;
  logic                          blank_seen_r;
  logic [NUMBER_DIGITS-1:0][3:0] digits_r;
  logic [NUMBER_DIGITS-1:0][3:0] digits_inc;

  logic       accept;
  logic       line_start;
  logic       is_nl;
  logic       squeezed;
  logic       num_en;
  logic [6:0] low;
  tlnef_cmd_t cmd;

  assign is_nl      = (in_data_byte == CH_NL);
  assign line_start = at_line_start_r | in_file_start;
  assign squeezed   = line_start & squeeze_blank_r & is_nl & blank_seen_r;
  assign num_en     = line_start & ~squeezed &
                      ((number_lines_r == NUM_ALL) ||
                       ((number_lines_r == NUM_NONBLANK) && !is_nl));
  assign in_ready   = push_ready;
  assign accept     = in_valid & in_ready;
  assign push_valid = in_valid & ~squeezed;
  assign low        = in_data_byte[6:0];

  // saturating decimal increment, index 0 most significant
  always_comb begin
    logic carry;
    logic full;
    carry = 1'b1;
    full  = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (digits_r[i] != 4'd9) full = 1'b0;
    end
    for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      if (carry && !full) begin
        digits_inc[i] = (digits_r[i] >= 4'd9) ? 4'd0 : digits_r[i] + 4'd1;
      end else begin
        digits_inc[i] = digits_r[i];
      end
      carry = carry & (digits_r[i] >= 4'd9);
    end
  end

  // character expansion
  always_comb begin
    cmd            = '0;
    cmd.num_en     = num_en;
    cmd.chars[0]   = in_data_byte;
    cmd.chars_last = 2'd0;
    if (is_nl) begin
      if (show_ends_r) begin
        cmd.chars[0]   = CH_DOLLAR;
        cmd.chars[1]   = CH_NL;
        cmd.chars_last = 2'd1;
      end
    end else if (in_data_byte == CH_TAB && show_tabs_r) begin
      cmd.chars[0]   = CH_CARET;
      cmd.chars[1]   = CH_I;
      cmd.chars_last = 2'd1;
    end else if (show_nonprinting_r) begin
      if (in_data_byte[7]) begin
        cmd.chars[0] = CH_M;
        cmd.chars[1] = CH_DASH;
        if (low == LOW_DEL) begin
          cmd.chars[2]   = CH_CARET;
          cmd.chars[3]   = CH_QMARK;
          cmd.chars_last = 2'd3;
        end else if (low <= LOW_CTRL_MAX) begin
          cmd.chars[2]   = CH_CARET;
          cmd.chars[3]   = {1'b0, low} + CARET_OFFSET;
          cmd.chars_last = 2'd3;
        end else begin
          cmd.chars[2]   = {1'b0, low};
          cmd.chars_last = 2'd2;
        end
      end else if (low == LOW_DEL) begin
        cmd.chars[0]   = CH_CARET;
        cmd.chars[1]   = CH_QMARK;
        cmd.chars_last = 2'd1;
      end else if (low <= LOW_CTRL_MAX && in_data_byte != CH_TAB) begin
        cmd.chars[0]   = CH_CARET;
        cmd.chars[1]   = in_data_byte + CARET_OFFSET;
        cmd.chars_last = 2'd1;
      end
    end
  end

  assign push_cmd    = cmd;
  assign push_digits = num_en ? digits_inc : digits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_lines_r     <= '0;
      squeeze_blank_r    <= 1'b0;
      show_ends_r        <= 1'b0;
      show_tabs_r        <= 1'b0;
      show_nonprinting_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NUMBER_LINES:     number_lines_r     <= cfg_data[1:0];
        REG_SQUEEZE_BLANK:    squeeze_blank_r    <= cfg_data[0];
        REG_SHOW_ENDS:        show_ends_r        <= cfg_data[0];
        REG_SHOW_TABS:        show_tabs_r        <= cfg_data[0];
        REG_SHOW_NONPRINTING: show_nonprinting_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_line_start_r <= 1'b1;
      blank_seen_r    <= 1'b0;
      digits_r        <= '0;
    end else if (accept) begin
      at_line_start_r <= is_nl;
      if (line_start && squeeze_blank_r) blank_seen_r <= is_nl;
      if (num_en) digits_r <= digits_inc;
    end
  end

endmodule

FILE: rtl/core/tlnef_queue.sv
module tlnef_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tlnef_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import tlnef_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: rtl/core/tlnef_back.sv
module tlnef_back #(
  parameter int NUMBER_DIGITS = tlnef_pkg::NUMBER_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  tlnef_pkg::tlnef_cmd_t         pop_cmd,
  input  logic [NUMBER_DIGITS-1:0][3:0] pop_digits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          out_last
);
  import tlnef_pkg::*;

  localparam int POS_W = $clog2(NUMBER_DIGITS + 5);
  localparam int DIG_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
  localparam logic [POS_W-1:0] TAB_POS   = POS_W'(NUMBER_DIGITS);
  localparam logic [POS_W-1:0] CHAR_POS  = POS_W'(NUMBER_DIGITS + 1);
  localparam logic [POS_W-1:0] UNITS_POS = POS_W'(NUMBER_DIGITS - 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             lead_r, lead_nxt;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic [POS_W-1:0] eff_pos;
  logic [POS_W-1:0] char_off;
  logic [1:0]       char_idx;
  logic [3:0]       digit;
  logic             load;
  logic [7:0]       byte_sel;
  logic             last_sel;

  assign load     = pop_valid & (~out_valid_r | out_ready);
  assign eff_pos  = pop_cmd.num_en ? pos_r : pos_r + CHAR_POS;
  assign char_off = eff_pos - CHAR_POS;
  assign char_idx = char_off[1:0];
  assign digit    = pop_digits[eff_pos[DIG_W-1:0]];

  always_comb begin
    byte_sel = CH_SPACE;
    last_sel = 1'b0;
    lead_nxt = lead_r;
    if (eff_pos < TAB_POS) begin
      if (lead_r && digit == 4'd0 && eff_pos != UNITS_POS) begin
        byte_sel = CH_SPACE;
      end else begin
        byte_sel = CH_ZERO + {4'd0, digit};
        lead_nxt = 1'b0;
      end
    end else if (eff_pos == TAB_POS) begin
      byte_sel = CH_TAB;
    end else begin
      byte_sel = pop_cmd.chars[char_idx];
      last_sel = (char_idx == pop_cmd.chars_last);
    end
    pos_nxt = last_sel ? '0 : pos_r + 1'b1;
  end

  assign pop_ready = load & last_sel;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= byte_sel;
      out_last_r <= last_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      lead_r      <= 1'b1;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        pos_r       <= pos_nxt;
        lead_r      <= last_sel ? 1'b1 : lead_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/text_line_number_escape_filter.sv
// Byte stream filter in the style of cat -benstv. Each request on in_ch carries
// one byte and yields zero to NUMBER_DIGITS+5 bytes on out_ch, with last set on
// the final byte of that request. A plain byte passes at one byte per clock and
// an input byte may be taken every cycle; a request that expands into k bytes
// holds the output until the last, and input stalls once the two-entry queue
// between the classifying front and the emitting back is full. One output byte
// leaves per cycle while out_ch is ready. A line squeezed away is consumed with
// no output. Configuration must be written by the user on cfg_ch (always ready)
// only while the block is idle (not enforced). No clearing pass after reset.
module text_line_number_escape_filter #(
  parameter int NUMBER_DIGITS = tlnef_pkg::NUMBER_DIGITS_DEF,
  parameter int QUEUE_DEPTH   = tlnef_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tlnef_in_if.sink    in_ch,
  tlnef_out_if.source out_ch,
  tlnef_cfg_if.sink   cfg_ch
);
  import tlnef_pkg::*;

  // queue word: digit snapshot above the classified request
  localparam int Q_W = NUMBER_DIGITS * 4 + $bits(tlnef_cmd_t);

  logic                          push_valid, push_ready;
  tlnef_cmd_t                    push_cmd;
  logic [NUMBER_DIGITS-1:0][3:0] push_digits;
  logic                          pop_valid, pop_ready;
  logic [Q_W-1:0]                pop_data;
  tlnef_cmd_t                    pop_cmd;
  logic [NUMBER_DIGITS-1:0][3:0] pop_digits;

  // registers are plain flops, so writes never stall
  assign cfg_ch.ready = 1'b1;

  // front: line state, counter, squeeze and character expansion
  tlnef_front #(
    .NUMBER_DIGITS (NUMBER_DIGITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_data_byte  (in_ch.data_byte),
    .in_file_start (in_ch.file_start),
    .cfg_valid     (cfg_ch.valid),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_cmd      (push_cmd),
    .push_digits   (push_digits)
  );

  // decoupling queue
  tlnef_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_digits, push_cmd}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_cmd    = pop_data[$bits(tlnef_cmd_t)-1:0];
  assign pop_digits = pop_data[Q_W-1:$bits(tlnef_cmd_t)];

  // back: walks number digits, tab and characters into the output register
  tlnef_back #(
    .NUMBER_DIGITS (NUMBER_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .pop_digits (pop_digits),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .out_last   (out_ch.last)
  );

endmodule

FILE: sim/text_line_number_escape_filter_test.sv
module text_line_number_escape_filter_test;
  import tlnef_pkg::*;

  localparam int DIGITS         = NUMBER_DIGITS_DEF;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 51;
  localparam int SETTLE_CYCLES  = 20;     // queue of two plus output register, with room to spare
  localparam int LONG_HOLD      = 200;
  localparam int CYCLE_LIMIT    = 400000;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  // one line of the directed plan: a byte request or a register write
  typedef struct {
    row_kind_t  kind;
    logic [7:0] val;    // data byte, or register index
    logic [7:0] aux;    // file_start in bit 0, or register value
    bit         typed;  // expected bytes given below instead of predicted
    string      text;
  } row_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last;
  } shown_byte_t;

  logic clk;
  logic rst_n;

  tlnef_in_if  in_ch ();
  tlnef_out_if out_ch ();
  tlnef_cfg_if cfg_ch ();

  text_line_number_escape_filter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor copy of the registers
  logic [1:0] num_mode;
  logic       squeeze_on;
  logic       ends_on;
  logic       tabs_on;
  logic       nonprint_on;

  // predictor copy of the line state
  logic       line_start;
  logic       blank_seen;
  logic [3:0] line_digits [DIGITS];   // index 0 is the most significant digit

  logic [7:0]  rendered [$];          // bytes one request turns into
  shown_byte_t pending_out [$];       // bytes still owed by the block, oldest first

  bit    row_typed;
  string row_text;

  bit          tx_calm;
  bit          rx_calm;
  int unsigned rx_gap;
  int unsigned rx_hold_cycles;
  int unsigned mismatches;
  int unsigned bytes_seen;
  int unsigned cycle_count;

  // directed plan; the counter at all nines is not reached here, as it takes
  // close to a million numbered lines
  row_t plan [$] = '{
    // straight after reset every mode is off, bytes pass unchanged
    '{ROW_BYTE, "A",    8'd0, 1'b1, "A"},
    '{ROW_BYTE, 8'h00,  8'd0, 1'b0, ""},
    '{ROW_BYTE, 8'hFF,  8'd0, 1'b1, "\377"},
    '{ROW_BYTE, CH_TAB, 8'd0, 1'b1, "\t"},
    '{ROW_BYTE, CH_NL,  8'd0, 1'b1, "\n"},
    // every mode on
    '{ROW_CFG, 8'(REG_NUMBER_LINES),     8'd1, 1'b0, ""},
    '{ROW_CFG, 8'(REG_SQUEEZE_BLANK),    8'd1, 1'b0, ""},
    '{ROW_CFG, 8'(REG_SHOW_ENDS),        8'd1, 1'b0, ""},
    '{ROW_CFG, 8'(REG_SHOW_TABS),        8'd1, 1'b0, ""},
    '{ROW_CFG, 8'(REG_SHOW_NONPRINTING), 8'd1, 1'b0, ""},
    '{ROW_BYTE, "x",    8'd0, 1'b1, "     1\tx"},
    '{ROW_BYTE, CH_NL,  8'd0, 1'b1, "$\n"},
    '{ROW_BYTE, CH_NL,  8'd0, 1'b1, "     2\t$\n"},
    // second empty line in a row is squeezed away
    '{ROW_BYTE, CH_NL,  8'd0, 1'b1, ""},
    // longest expansion: number, tab and M-^@
    '{ROW_BYTE, 8'h80,  8'd0, 1'b1, "     3\tM-^@"},
    '{ROW_BYTE, 8'hFF,  8'd0, 1'b1, "M-^?"},
    '{ROW_BYTE, 8'h7F,  8'd0, 1'b1, "^?"},
    '{ROW_BYTE, CH_TAB, 8'd0, 1'b1, "^I"},
    '{ROW_BYTE, 8'h89,  8'd0, 1'b1, "M-^I"},
    '{ROW_BYTE, 8'h8A,  8'd0, 1'b0, ""},
    '{ROW_BYTE, 8'h01,  8'd0, 1'b1, "^A"},
    '{ROW_BYTE, 8'hC1,  8'd0, 1'b1, "M-A"},
    // new file forces a line start mid-line
    '{ROW_BYTE, "q",    8'd1, 1'b1, "     4\tq"},
    // tab stays raw without show_tabs; blank lines not numbered
    '{ROW_CFG, 8'(REG_SHOW_TABS),    8'd0, 1'b0, ""},
    '{ROW_CFG, 8'(REG_NUMBER_LINES), 8'd2, 1'b0, ""},
    '{ROW_BYTE, CH_TAB, 8'd0, 1'b1, "\t"},
    '{ROW_BYTE, CH_NL,  8'd0, 1'b1, "$\n"},
    '{ROW_BYTE, CH_NL,  8'd0, 1'b1, "$\n"},
    '{ROW_BYTE, "b",    8'd0, 1'b1, "     5\tb"},
    // numbering mode three means no numbering
    '{ROW_CFG, 8'(REG_NUMBER_LINES),     8'd3, 1'b0, ""},
    '{ROW_CFG, 8'(REG_SHOW_NONPRINTING), 8'd0, 1'b0, ""},
    '{ROW_CFG, 8'(REG_SHOW_ENDS),        8'd0, 1'b0, ""},
    '{ROW_CFG, 8'(REG_SQUEEZE_BLANK),    8'd0, 1'b0, ""},
    '{ROW_BYTE, 8'h8A,  8'd1, 1'b1, "\212"},
    // index past the last register is ignored, wide values are masked
    '{ROW_CFG, 8'd5,                 8'hFF, 1'b0, ""},
    '{ROW_CFG, 8'(REG_NUMBER_LINES), 8'hFE, 1'b0, ""},
    '{ROW_BYTE, 8'h7F,  8'd1, 1'b1, "     6\t\177"}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // expansion of one request, updating the predicted line state
  function automatic void render_request(input logic [7:0] c, input logic fs);
    logic [6:0] low;
    bit         lead;
    bit         full;
    int         i;
    rendered.delete();
    if (fs) line_start = 1'b1;
    if (line_start) begin
      if (squeeze_on) begin
        if (c == CH_NL) begin
          // repeated empty line: nothing out, nothing changes
          if (blank_seen) return;
          blank_seen = 1'b1;
        end else begin
          blank_seen = 1'b0;
        end
      end
      if (num_mode == NUM_ALL || (num_mode == NUM_NONBLANK && c != CH_NL)) begin
        // decimal count, held once every digit is nine
        full = 1'b1;
        for (i = 0; i < DIGITS; i++) begin
          if (line_digits[i] != 4'd9) full = 1'b0;
        end
        if (!full) begin
          for (i = DIGITS - 1; i >= 0; i--) begin
            if (line_digits[i] == 4'd9) begin
              line_digits[i] = 4'd0;
            end else begin
              line_digits[i] = line_digits[i] + 4'd1;
              break;
            end
          end
        end
        // leading zeros become spaces, the last digit always shows
        lead = 1'b1;
        for (i = 0; i < DIGITS; i++) begin
          if (lead && line_digits[i] == 4'd0 && i != DIGITS - 1) begin
            rendered.push_back(CH_SPACE);
          end else begin
            lead = 1'b0;
            rendered.push_back(CH_ZERO + {4'd0, line_digits[i]});
          end
        end
        rendered.push_back(CH_TAB);
      end
    end

    low = c[6:0];
    if (c == CH_NL) begin
      if (ends_on) rendered.push_back(CH_DOLLAR);
      rendered.push_back(c);
    end else if (c == CH_TAB && tabs_on) begin
      rendered.push_back(CH_CARET);
      rendered.push_back(CH_I);
    end else if (nonprint_on) begin
      if (c[7]) begin
        rendered.push_back(CH_M);
        rendered.push_back(CH_DASH);
      end
      if (low == LOW_DEL) begin
        rendered.push_back(CH_CARET);
        rendered.push_back(CH_QMARK);
      end else if (low <= LOW_CTRL_MAX && (c[7] || (c != CH_TAB && c != CH_NL))) begin
        // tab and newline only get caret notation in the high half
        rendered.push_back(CH_CARET);
        rendered.push_back({1'b0, low} + CARET_OFFSET);
      end else begin
        rendered.push_back({1'b0, low});
      end
    end else begin
      rendered.push_back(c);
    end
    line_start = (c == CH_NL);
  endfunction

  // everything at the rising edge: outputs first, then writes, then requests
  always @(posedge clk) begin : watch
    shown_byte_t got;
    shown_byte_t want;
    int          k;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{text_byte: out_ch.out_byte, last: out_ch.last};
        if (pending_out.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("output byte %0d: %02h last %0b with no request pending",
                     bytes_seen, got.text_byte, got.last);
        end else begin
          want = pending_out.pop_front();
          if (got.text_byte !== want.text_byte || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("output byte %0d: expected %02h last %0b, got %02h last %0b",
                       bytes_seen, want.text_byte, want.last, got.text_byte, got.last);
          end
        end
        bytes_seen++;
        // fresh receiver gap for the next byte
        rx_gap = rx_calm ? 0 : $urandom_range(0, 14);
      end

      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_NUMBER_LINES:     num_mode    = cfg_ch.data[1:0];
          REG_SQUEEZE_BLANK:    squeeze_on  = cfg_ch.data[0];
          REG_SHOW_ENDS:        ends_on     = cfg_ch.data[0];
          REG_SHOW_TABS:        tabs_on     = cfg_ch.data[0];
          REG_SHOW_NONPRINTING: nonprint_on = cfg_ch.data[0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        render_request(in_ch.data_byte, in_ch.file_start);
        // a typed row replaces the prediction, the line state still moves on
        if (row_typed) begin
          for (k = 0; k < row_text.len(); k++)
            pending_out.push_back('{text_byte: row_text[k], last: (k == row_text.len() - 1)});
        end else begin
          for (k = 0; k < rendered.size(); k++)
            pending_out.push_back('{text_byte: rendered[k], last: (k == rendered.size() - 1)});
        end
      end
    end
  end

  // receiver: long hold-off first, then the per-byte gap
  always @(negedge clk) begin
    if (rx_hold_cycles != 0) begin
      rx_hold_cycles--;
      out_ch.ready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // one byte request, after a random gap
  task automatic push_byte(input logic [7:0] b, input logic fs, input bit typed,
                           input string text);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      @(negedge clk) in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.file_start <= fs;
    row_typed = typed;
    row_text  = text;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk) cfg_ch.valid <= 1'b0;
  endtask

  // stop sending, let every owed byte out, then allow for a squeezed line in flight
  task automatic settle();
    @(negedge clk) in_ch.valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int         p;
    int         j;
    logic [7:0] b;
    logic       fs;
    bit         noise;

    // known values on every input from time zero
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = 8'd0;
    in_ch.file_start  = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    row_typed         = 1'b0;
    row_text          = "";
    tx_calm           = 1'b0;
    rx_calm           = 1'b0;
    rx_gap            = 0;
    rx_hold_cycles    = 0;
    mismatches        = 0;
    bytes_seen        = 0;

    // predictor state as after reset
    num_mode    = 2'd0;
    squeeze_on  = 1'b0;
    ends_on     = 1'b0;
    tabs_on     = 1'b0;
    nonprint_on = 1'b0;
    line_start  = 1'b1;
    blank_seen  = 1'b0;
    for (j = 0; j < DIGITS; j++) line_digits[j] = 4'd0;

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed plan
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        settle();
        write_reg(plan[r].val[CFG_IDX_W-1:0], plan[r].aux);
      end else begin
        push_byte(plan[r].val, plan[r].aux[0], plan[r].typed, plan[r].text);
      end
    end

    // random phases, each under its own register setting
    for (p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin
          // every mode on, numbering non-blank lines
          write_reg(REG_NUMBER_LINES, 8'd2);
          write_reg(REG_SQUEEZE_BLANK, 8'd1);
          write_reg(REG_SHOW_ENDS, 8'd1);
          write_reg(REG_SHOW_TABS, 8'd1);
          write_reg(REG_SHOW_NONPRINTING, 8'd1);
        end
        1: begin
          // everything off
          write_reg(REG_NUMBER_LINES, 8'd0);
          write_reg(REG_SQUEEZE_BLANK, 8'd0);
          write_reg(REG_SHOW_ENDS, 8'd0);
          write_reg(REG_SHOW_TABS, 8'd0);
          write_reg(REG_SHOW_NONPRINTING, 8'd0);
        end
        default: begin
          write_reg(REG_NUMBER_LINES, CFG_DATA_W'($urandom_range(0, 255)));
          write_reg(REG_SQUEEZE_BLANK, CFG_DATA_W'($urandom_range(0, 255)));
          write_reg(REG_SHOW_ENDS, CFG_DATA_W'($urandom_range(0, 255)));
          write_reg(REG_SHOW_TABS, CFG_DATA_W'($urandom_range(0, 255)));
          write_reg(REG_SHOW_NONPRINTING, CFG_DATA_W'($urandom_range(0, 255)));
          if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom_range(0, 255)));
        end
      endcase

      tx_calm = (p == 0) || ($urandom_range(0, 3) == 0);
      rx_calm = (p == 0) || ($urandom_range(0, 3) == 0);
      noise   = (p == PHASES - 1);

      // receiver stalls for a long while as the sender keeps offering requests
      if (p == 2) begin
        tx_calm        = 1'b1;
        rx_hold_cycles = LONG_HOLD;
      end

      for (j = 0; j < PHASE_ITEMS; j++) begin
        // sender waits out every owed byte halfway through one phase
        if (p == 3 && j == PHASE_ITEMS / 2) settle();
        if (noise) begin
          b = 8'($urandom_range(0, 255));
        end else begin
          // text-like mix, newlines frequent enough to form runs of empty lines
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: b = CH_NL;
            5, 6:          b = CH_TAB;
            7, 8:          b = 8'($urandom_range(0, 31));
            9, 10:         b = 8'($urandom_range(128, 255));
            11:            b = $urandom_range(0, 1) ? 8'h7F : 8'hFF;
            default:       b = 8'($urandom_range(32, 126));
          endcase
        end
        fs = ($urandom_range(0, 19) == 0);
        push_byte(b, fs, 1'b0, "");
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/tlnef_pkg.sv
rtl/core/tlnef_if.sv
rtl/core/tlnef_front.sv
rtl/core/tlnef_queue.sv
rtl/core/tlnef_back.sv
rtl/core/text_line_number_escape_filter.sv
sim/text_line_number_escape_filter_test.sv
